[hw/rtl/cfb_pkg.sv]
// ----------------------------------------------------------------------------
// cfb_pkg
// Types, constants and the CRC byte step shared by the command frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

  localparam int unsigned JOB_KIND_W = 2;

  localparam logic [JOB_KIND_W-1:0] KIND_ERR = 2'd0;
  localparam logic [JOB_KIND_W-1:0] KIND_HDR = 2'd1;
  localparam logic [JOB_KIND_W-1:0] KIND_ARG = 2'd2;

  localparam logic CMD_HDR = 1'b0;
  localparam logic CMD_ARG = 1'b1;

  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  localparam logic [7:0] SYNC_BYTES [4] = '{8'hEB, 8'h90, 8'h5B, 8'h6A};
  localparam logic [7:0] TRAIL_BYTES [4] = '{8'hC5, 8'hA4, 8'hD2, 8'h79};

  // Byte counter positions within one job.
  localparam logic [3:0] POS_HDR_LAST = 4'd7;
  localparam logic [3:0] POS_ARG_LAST = 4'd3;
  localparam logic [3:0] POS_TAIL_FIRST = 4'd8;
  localparam logic [3:0] POS_TAIL_LAST = 4'd13;

  // One unit of work handed from the front end to the byte sequencer.
  typedef struct packed {
    logic [JOB_KIND_W-1:0] kind;
    logic                  close;  // frame closes after this job's bytes
    logic [31:0]           data;   // {code, arg_count} or the argument word
  } job_t;

  // Reflected CRC-16, one byte, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/cfb_front.sv]
// ----------------------------------------------------------------------------
// cfb_front
// Accepts input items, checks them against the frame order and queues jobs.
// ----------------------------------------------------------------------------
module cfb_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [63:0]   s_tdata,
  input  logic          s_tuser,
  input  logic          q_full,
  output logic          q_push,
  output cfb_pkg::job_t q_job
);
  import cfb_pkg::*;

  logic        frame_open;
  logic [15:0] args_left;
  logic        frame_open_next;
  logic [15:0] args_left_next;

  logic [15:0] code;
  logic [15:0] arg_count;
  logic [31:0] arg;

  assign code      = s_tdata[15:0];
  assign arg_count = s_tdata[31:16];
  assign arg       = s_tdata[63:32];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    frame_open_next = frame_open;
    args_left_next  = args_left;
    q_job.kind  = KIND_ERR;
    q_job.close = 1'b0;
    q_job.data  = 32'h0;
    if (s_tuser == CMD_HDR) begin
      if (!frame_open) begin
        q_job.kind      = KIND_HDR;
        q_job.data      = {code, arg_count};
        q_job.close     = (arg_count == 16'h0);
        frame_open_next = (arg_count != 16'h0);
        args_left_next  = arg_count;
      end
    end else begin
      if (frame_open) begin
        q_job.kind      = KIND_ARG;
        q_job.data      = arg;
        q_job.close     = (args_left == 16'h1);
        frame_open_next = (args_left != 16'h1);
        args_left_next  = args_left - 16'h1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      args_left  <= 16'h0;
    end else if (q_push) begin
      frame_open <= frame_open_next;
      args_left  <= args_left_next;
    end
  end

endmodule

[hw/rtl/cfb_fifo.sv]
// ----------------------------------------------------------------------------
// cfb_fifo
// Small register queue of jobs between the front end and the sequencer.
// ----------------------------------------------------------------------------
module cfb_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cfb_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output cfb_pkg::job_t pop_job,
  output logic          not_empty
);
  import cfb_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/cfb_back.sv]
// ----------------------------------------------------------------------------
// cfb_back
// Byte sequencer: turns queued jobs into frame bytes and keeps the CRC.
// ----------------------------------------------------------------------------
module cfb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cfb_pkg::job_t q_job,
  output logic          q_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,
  output logic          m_tlast,
  output logic          m_tuser
);
  import cfb_pkg::*;

  logic        cur_valid;
  job_t        cur;
  logic [3:0]  pos;
  logic [15:0] crc;

  logic        advance;
  logic        emit;
  logic        job_done;
  logic [7:0]  byte_val;
  logic        byte_last;
  logic        byte_err;
  logic        byte_in_crc;
  logic [15:0] crc_base;
  logic [3:0]  pos_next;
  logic [1:0]  sel;

  assign advance = !m_tvalid || m_tready;
  assign emit    = advance && cur_valid;
  assign sel     = pos[1:0];

  always_comb begin
    byte_val    = 8'h00;
    byte_last   = 1'b0;
    byte_err    = 1'b0;
    byte_in_crc = 1'b0;
    job_done    = 1'b0;
    pos_next    = pos + 4'd1;
    if (cur.kind == KIND_ERR) begin
      byte_err = 1'b1;
      job_done = 1'b1;
    end else if (pos[3]) begin
      // Closing bytes: CRC high, CRC low, then the trailer.
      case (pos[2:0])
        3'd0:    byte_val = crc[15:8];
        3'd1:    byte_val = crc[7:0];
        default: byte_val = TRAIL_BYTES[2'(pos[2:0] - 3'd2)];
      endcase
      byte_last = (pos == POS_TAIL_LAST);
      job_done  = byte_last;
    end else begin
      byte_in_crc = 1'b1;
      if (cur.kind == KIND_HDR && !pos[2]) begin
        byte_val = SYNC_BYTES[sel];
      end else begin
        case (sel)
          2'd0:    byte_val = cur.data[31:24];
          2'd1:    byte_val = cur.data[23:16];
          2'd2:    byte_val = cur.data[15:8];
          default: byte_val = cur.data[7:0];
        endcase
      end
      if ((cur.kind == KIND_HDR && pos == POS_HDR_LAST) ||
          (cur.kind == KIND_ARG && pos == POS_ARG_LAST)) begin
        if (cur.close) begin
          pos_next = POS_TAIL_FIRST;
        end else begin
          job_done = 1'b1;
        end
      end
    end
  end

  // A header starts a fresh CRC on its first sync byte.
  assign crc_base = (cur.kind == KIND_HDR && pos == 4'd0) ? CRC_INIT : crc;

  // Load the next job when idle or on the last byte of the current one.
  assign q_pop = q_valid && (!cur_valid || (emit && job_done));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= 4'd0;
      crc       <= CRC_INIT;
      m_tvalid  <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= cur_valid;
      end
      if (emit && byte_in_crc) begin
        crc <= crc16_byte(crc_base, byte_val);
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        pos       <= 4'd0;
      end else if (emit) begin
        if (job_done) begin
          cur_valid <= 1'b0;
        end
        pos <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
    if (emit) begin
      m_tdata <= byte_val;
      m_tlast <= byte_last;
      m_tuser <= byte_err;
    end
  end

endmodule

[hw/rtl/command_frame_builder_crc16.sv]
// ----------------------------------------------------------------------------
// command_frame_builder_crc16
// Command framer: header and argument items in, framed bytes with CRC-16 out.
// ----------------------------------------------------------------------------
// The output port moves one byte per cycle while m_tready is high and jobs
// are queued. An argument item gives 4 bytes (10 when it closes the frame), a
// header gives 8 bytes (14 when its count is zero), and an item out of frame
// order gives a single error byte. The front end checks each item against the
// frame order as it is accepted and places a job in a queue of FIFO_DEPTH
// entries, so input transfers continue while the sequencer still sends bytes;
// s_tready drops only when that queue is full. The CRC is the reflected
// CRC-16 with polynomial 0x8408 and initial value 0, computed one byte per
// cycle as bytes are sent over the sync, code, count and argument bytes, sent high byte first.
module command_frame_builder_crc16 #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // code[15:0], arg_count[31:16], arg[63:32]
  input  logic        s_tuser,   // cmd: 0 header, 1 argument
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast,   // frame_end
  output logic        m_tuser    // error
);
  import cfb_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  job_t push_job;
  job_t pop_job;

  cfb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  cfb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_job   (pop_job),
    .not_empty (q_not_empty)
  );

  cfb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_not_empty),
    .q_job    (pop_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  // An error transfer never closes a frame and always carries a zero byte.
  a_err_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> !m_tlast)
    else $error("error transfer marked as frame end");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 8'h00))
    else $error("error transfer with nonzero byte");

  // The last transfer of a frame is always the final trailer byte.
  a_last_trailer: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata == TRAIL_BYTES[3]))
    else $error("frame end on a byte other than the final trailer byte");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

[test/command_frame_builder_crc16_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_frame_builder_crc16_test
// Self-checking bench for the CRC-16 command frame builder. Header and
// argument items go in on the input stream. A predictor rebuilds every framed
// byte, including the running CRC, the trailer and the order-error results.
// Each output transfer is compared with the oldest predicted byte. The sender
// works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module command_frame_builder_crc16_test;
  import cfb_pkg::*;

  typedef struct {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       error;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  // Predictor state.
  logic [15:0] run_crc = CRC_INIT;
  logic [15:0] words_left = '0;
  logic        in_frame = 1'b0;
  frame_byte_t expected_bytes[$];

  // Sender burst control.
  int burst_left = 0;
  bit gapless = 1'b0;

  // Receiver long hold-off request, taken over by the receiver process.
  int hold_request = 0;

  int fail_count = 0;
  int bytes_checked = 0;
  int frames_closed = 0;
  int order_errors = 0;
  int random_items = 0;

  command_frame_builder_crc16 dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Bitwise form of the reflected CRC-16: feedback is the low CRC bit xor
  // the next data bit, least significant data bit first.
  function automatic logic [15:0] crc_after_byte(input logic [15:0] crc,
                                                 input logic [7:0]  b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic last,
                                    input logic err);
    frame_byte_t fb;
    fb.out_byte = b;
    fb.frame_end = last;
    fb.error = err;
    expected_bytes.insert(expected_bytes.size(), fb);
  endfunction

  function automatic void push_covered(input logic [7:0] b);
    run_crc = crc_after_byte(run_crc, b);
    push_byte(b, 1'b0, 1'b0);
  endfunction

  function automatic void push_frame_tail();
    push_byte(run_crc[15:8], 1'b0, 1'b0);
    push_byte(run_crc[7:0], 1'b0, 1'b0);
    for (int i = 0; i < 4; i++) begin
      push_byte(TRAIL_BYTES[i], i == 3, 1'b0);
    end
    in_frame = 1'b0;
    words_left = '0;
  endfunction

  // Works out every byte that one accepted item causes.
  function automatic void predict_frame_bytes(input logic cmd, input logic [15:0] code,
                                              input logic [15:0] cnt,
                                              input logic [31:0] arg);
    if (cmd == CMD_HDR) begin
      if (in_frame) begin
        push_byte(8'h00, 1'b0, 1'b1);
      end else begin
        run_crc = CRC_INIT;
        for (int i = 0; i < 4; i++) begin
          push_covered(SYNC_BYTES[i]);
        end
        push_covered(code[15:8]);
        push_covered(code[7:0]);
        push_covered(cnt[15:8]);
        push_covered(cnt[7:0]);
        if (cnt == 16'd0) begin
          push_frame_tail();
        end else begin
          in_frame = 1'b1;
          words_left = cnt;
        end
      end
    end else if (!in_frame) begin
      push_byte(8'h00, 1'b0, 1'b1);
    end else begin
      push_covered(arg[31:24]);
      push_covered(arg[23:16]);
      push_covered(arg[15:8]);
      push_covered(arg[7:0]);
      words_left = words_left - 16'd1;
      if (words_left == 16'd0) begin
        push_frame_tail();
      end
    end
  endfunction

  // Offers one item, in bursts of random length with random gaps between.
  task automatic send_item(input logic cmd, input logic [15:0] code,
                           input logic [15:0] cnt, input logic [31:0] arg);
    int gap;
    if (burst_left == 0 && !gapless) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {arg, cnt, code};
    do begin
      @(posedge clk);
    end while (!s_tready);
    predict_frame_bytes(cmd, code, cnt, arg);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_arg();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: changes its stall pattern now and then, and honors a long
  // hold-off when one is requested.
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_hold_left = 0;
  int rx_phase = 0;
  always @(posedge clk) begin
    if (hold_request != 0) begin
      rx_hold_left = hold_request;
      hold_request = 0;
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(40, 300);
    end
    rx_mode_left--;
    rx_phase++;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 9) < 7);
        2: m_tready <= ($urandom_range(0, 9) < 3);
        default: m_tready <= ((rx_phase % 7) < 3);
      endcase
    end
  end

  // Compares each output transfer with the oldest predicted byte.
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output transfer: byte %02h last %0b error %0b",
               m_tdata, m_tlast, m_tuser);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (m_tdata !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, m_tdata);
          fail_count++;
        end
        if (m_tlast !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, m_tlast);
          fail_count++;
        end
        if (m_tuser !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, m_tuser);
          fail_count++;
        end
        if (want.frame_end) frames_closed++;
        if (want.error) order_errors++;
      end
    end
  end

  task automatic test_stray_argument();
    send_item(CMD_ARG, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
  endtask

  task automatic test_empty_frames();
    send_item(CMD_HDR, 16'h0000, 16'h0000, 32'h0000_0000);
    send_item(CMD_HDR, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_single_argument();
    send_item(CMD_HDR, 16'h1234, 16'h0001, 32'h0);
    send_item(CMD_ARG, 16'h0000, 16'h0000, 32'h8000_0000);
  endtask

  task automatic test_header_while_open();
    send_item(CMD_HDR, 16'hA5C3, 16'h0002, 32'h0);
    send_item(CMD_HDR, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_ARG, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(CMD_ARG, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_argument_extremes();
    send_item(CMD_HDR, 16'h00FF, 16'h0004, 32'h0);
    send_item(CMD_ARG, 16'h0, 16'h0, 32'h0000_0000);
    send_item(CMD_ARG, 16'h0, 16'h0, 32'hFFFF_FFFF);
    send_item(CMD_ARG, 16'h0, 16'h0, 32'h0000_0001);
    send_item(CMD_ARG, 16'h0, 16'h0, 32'h5A5A_A5A5);
    send_item(CMD_ARG, 16'h0, 16'h0, 32'h1234_5678);
  endtask

  // The receiver holds off while the sender keeps offering, so the job queue
  // fills and the input stalls.
  task automatic test_backpressure();
    wait_drained();
    hold_request = 400;
    gapless = 1'b1;
    send_item(CMD_HDR, 16'($urandom), 16'd24, $urandom);
    for (int k = 0; k < 24; k++) begin
      send_item(CMD_ARG, 16'($urandom), 16'($urandom), $urandom);
    end
    gapless = 1'b0;
  endtask

  // The sender pauses until every byte is out, once inside an open frame and once before a new frame.
  task automatic test_drained_pause();
    send_item(CMD_HDR, 16'h0F0F, 16'd2, 32'h0);
    send_item(CMD_ARG, 16'h0, 16'h0, $urandom);
    wait_drained();
    send_item(CMD_ARG, 16'h0, 16'h0, $urandom);
    wait_drained();
    send_item(CMD_HDR, 16'hF0F0, 16'd0, 32'h0);
  endtask

  task automatic send_random_frame();
    logic [15:0] cnt;
    cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(5, 20))
                                      : 16'($urandom_range(0, 4));
    send_item(CMD_HDR, 16'($urandom), cnt, $urandom);
    random_items++;
    for (int k = 0; k < cnt; k++) begin
      // Stray header inside an open frame; its fields are random throughout.
      if ($urandom_range(0, 19) == 0) begin
        send_item(CMD_HDR, 16'($urandom), 16'($urandom), $urandom);
      end
      send_item(CMD_ARG, 16'($urandom), 16'($urandom), pick_arg());
      random_items++;
    end
    if ($urandom_range(0, 9) == 0) begin
      send_item(CMD_ARG, 16'($urandom), 16'($urandom), $urandom);
    end
  endtask

  task automatic test_random_frames();
    while (random_items < 360) begin
      send_random_frame();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_stray_argument();
    test_empty_frames();
    test_single_argument();
    test_header_while_open();
    test_argument_extremes();
    test_backpressure();
    test_drained_pause();
    test_random_frames();
    wait_drained();
    repeat (40) @(posedge clk);
    $display("Checked %0d bytes in %0d closed frames with %0d order errors,",
             bytes_checked, frames_closed, order_errors);
    $display("including a long receiver hold-off and a pause until drained.");
    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
